FILE: rtl/gpa_pkg.sv
// Shared types, constants and arithmetic helpers for the pointing-angle pipeline.
`default_nettype none

package gpa_pkg;

   // Build constants
   localparam int ITERATIONS  = 16;
   localparam int COORD_WIDTH = 32;

   // Field and datapath widths
   localparam int FIELD_W     = 32;
   localparam int ANGLE_OUT_W = 16;
   localparam int DATA_W      = 54;
   localparam int ANGLE_W     = 32;
   localparam int GUARD_SHIFT = 50 - COORD_WIDTH;
   localparam int Q_SHIFT     = 16;
   localparam int KINV_W      = 24;
   localparam int LO_W        = 16;
   localparam int CSR_INDEX_W = 2;

   localparam logic [KINV_W-1:0]         KINV_Q24    = 24'd10188014;
   localparam logic signed [ANGLE_W-1:0] HALF_PI_Q29 = 32'sd843314857;
   localparam int                        ANGLE_MAX   = 25736;

   // Register indexes of the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TARGET_X     = 2'd0,
      CSR_TARGET_Y     = 2'd1,
      CSR_TARGET_Z     = 2'd2,
      CSR_TARGET_VALID = 2'd3
   } csr_index_type;

   // Input word
   typedef struct packed {
      logic signed [FIELD_W-1:0] center_x;
      logic signed [FIELD_W-1:0] center_y;
      logic signed [FIELD_W-1:0] center_z;
   } req_type;

   // Result word
   typedef struct packed {
      logic signed [ANGLE_OUT_W-1:0] pitch_angle;
      logic signed [ANGLE_OUT_W-1:0] yaw_angle;
      logic                          no_target;
   } rsp_type;

   // Data that rides along with a vector through the pipeline
   typedef struct packed {
      logic                        no_target;
      logic signed [DATA_W-1:0]    aux_y;
      logic signed [ANGLE_W-1:0]   aux_z;
   } side_type;

   // One CORDIC stage: vector, accumulated angle, zero-vector flag
   typedef struct packed {
      logic signed [DATA_W-1:0]  x;
      logic signed [DATA_W-1:0]  y;
      logic signed [ANGLE_W-1:0] z;
      logic                      zero;
   } cordic_type;

   // Sign-extend a coordinate from bit COORD_WIDTH-1
   function automatic logic signed [COORD_WIDTH:0] coord_ext(input logic [FIELD_W-1:0] v);
      logic [63:0]                    vw;
      logic signed [COORD_WIDTH-1:0]  t;
      vw = 64'(v);
      t  = vw[COORD_WIDTH-1:0];
      return (COORD_WIDTH+1)'(t);
   endfunction

   // atan(2^-i) in Q.29 radians, rounded to nearest
   function automatic logic signed [ANGLE_W-1:0] atan_entry(input int i);
      logic signed [ANGLE_W-1:0] r;
      case (i)
         0:       r = 32'sd421657428;
         1:       r = 32'sd248918915;
         2:       r = 32'sd131521918;
         3:       r = 32'sd66762579;
         4:       r = 32'sd33510843;
         5:       r = 32'sd16771758;
         6:       r = 32'sd8387925;
         7:       r = 32'sd4194219;
         8:       r = 32'sd2097141;
         9:       r = 32'sd1048575;
         default: r = (i <= 29) ? ANGLE_W'(64'sd1 <<< (29 - i)) : '0;
      endcase
      return r;
   endfunction

   // Round Q.29 half up to Q.13 and saturate to +-pi
   function automatic logic signed [ANGLE_OUT_W-1:0] to_q13(
      input logic signed [ANGLE_W-1:0] z
   );
      logic signed [ANGLE_W:0]         zr;
      logic signed [ANGLE_W-Q_SHIFT:0] a;
      logic signed [ANGLE_W-Q_SHIFT:0] lim;
      logic signed [ANGLE_OUT_W-1:0]   r;
      zr  = (ANGLE_W+1)'(z) + (ANGLE_W+1)'(33'sd1 <<< (Q_SHIFT-1));
      a   = (ANGLE_W-Q_SHIFT+1)'(zr >>> Q_SHIFT);
      lim = (ANGLE_W-Q_SHIFT+1)'(ANGLE_MAX);
      if (a > lim) begin
         r = ANGLE_OUT_W'(lim);
      end else if (a < -lim) begin
         r = ANGLE_OUT_W'(-lim);
      end else begin
         r = ANGLE_OUT_W'(a);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/gpa_cordic_pass.sv
// One CORDIC vectoring pass: quadrant pre-rotation stage plus one stage per micro-rotation.
`default_nettype none

module gpa_cordic_pass (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  logic                                   in_valid,
   input  logic signed [gpa_pkg::DATA_W-1:0]      in_x,
   input  logic signed [gpa_pkg::DATA_W-1:0]      in_y,
   input  gpa_pkg::side_type                      in_side,
   output logic                                   out_valid,
   output logic signed [gpa_pkg::DATA_W-1:0]      out_mag,
   output logic signed [gpa_pkg::ANGLE_W-1:0]     out_angle,
   output gpa_pkg::side_type                      out_side
);
   import gpa_pkg::*;

   logic [ITERATIONS:0] valid_ff;
   cordic_type          stage_in [0:ITERATIONS];
   cordic_type          stage_ff [0:ITERATIONS];
   side_type            side_ff  [0:ITERATIONS];

   // Fold the left half plane into the right one, flag the zero vector
   always_comb begin
      stage_in[0].zero = (in_x == '0) && (in_y == '0);
      stage_in[0].x    = in_x;
      stage_in[0].y    = in_y;
      stage_in[0].z    = '0;
      if (in_x[DATA_W-1]) begin
         if (!in_y[DATA_W-1]) begin
            stage_in[0].x = in_y;
            stage_in[0].y = -in_x;
            stage_in[0].z = HALF_PI_Q29;
         end else begin
            stage_in[0].x = -in_y;
            stage_in[0].y = in_x;
            stage_in[0].z = -HALF_PI_Q29;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff[0] <= stage_in[0];
         side_ff[0]  <= in_side;
      end
   end

   // One micro-rotation per stage, driving y toward zero
   for (genvar k = 1; k <= ITERATIONS; k++) begin : g_iter
      always_comb begin
         stage_in[k] = stage_ff[k-1];
         if (!stage_ff[k-1].y[DATA_W-1]) begin
            stage_in[k].x = stage_ff[k-1].x + ($signed(stage_ff[k-1].y) >>> (k-1));
            stage_in[k].y = stage_ff[k-1].y - ($signed(stage_ff[k-1].x) >>> (k-1));
            stage_in[k].z = stage_ff[k-1].z + atan_entry(k-1);
         end else begin
            stage_in[k].x = stage_ff[k-1].x - ($signed(stage_ff[k-1].y) >>> (k-1));
            stage_in[k].y = stage_ff[k-1].y + ($signed(stage_ff[k-1].x) >>> (k-1));
            stage_in[k].z = stage_ff[k-1].z - atan_entry(k-1);
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            stage_ff[k] <= stage_in[k];
            side_ff[k]  <= side_ff[k-1];
         end
      end
   end

   // Advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[ITERATIONS-1:0], in_valid};
      end
   end

   // Zero vector reads as angle zero
   assign out_valid = valid_ff[ITERATIONS];
   assign out_mag   = stage_ff[ITERATIONS].x;
   assign out_angle = stage_ff[ITERATIONS].zero ? '0 : stage_ff[ITERATIONS].z;
   assign out_side  = side_ff[ITERATIONS];

endmodule

`default_nettype wire

FILE: rtl/gpa_gain.sv
// Two-stage multiply of the first-pass length by the inverse CORDIC gain.
`default_nettype none

module gpa_gain (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  logic signed [gpa_pkg::DATA_W-1:0]  in_mag,
   input  gpa_pkg::side_type                  in_side,
   output logic                               out_valid,
   output logic signed [gpa_pkg::DATA_W-1:0]  out_len,
   output gpa_pkg::side_type                  out_side
);
   import gpa_pkg::*;

   localparam int HI_W  = DATA_W - LO_W;
   localparam int PHI_W = HI_W + KINV_W;
   localparam int PLO_W = LO_W + KINV_W;

   logic [1:0]               valid_ff;
   logic [DATA_W-1:0]        mag_u;
   logic [PHI_W-1:0]         phi_in;
   logic [PHI_W-1:0]         phi_ff;
   logic [PLO_W-1:0]         plo_full;
   logic [KINV_W-1:0]        plo_in;
   logic [KINV_W-1:0]        plo_ff;
   logic [PHI_W-1:0]         sum;
   logic signed [DATA_W-1:0] len_in;
   logic signed [DATA_W-1:0] len_ff;
   side_type                 side1_ff;
   side_type                 side2_ff;

   // Clamp to non-negative and split into high and low parts
   always_comb begin
      mag_u    = (in_mag > 0) ? in_mag : '0;
      phi_in   = PHI_W'(mag_u[DATA_W-1:LO_W]) * PHI_W'(KINV_Q24);
      plo_full = PLO_W'(mag_u[LO_W-1:0]) * PLO_W'(KINV_Q24);
      plo_in   = plo_full[PLO_W-1:LO_W];
   end

   // Add partial products and drop the extra fraction bits
   always_comb begin
      sum    = phi_ff + PHI_W'(plo_ff);
      len_in = DATA_W'(sum >> (KINV_W - LO_W));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         phi_ff   <= phi_in;
         plo_ff   <= plo_in;
         side1_ff <= in_side;
         len_ff   <= len_in;
         side2_ff <= side1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[0], in_valid};
      end
   end

   assign out_valid = valid_ff[1];
   assign out_len   = len_ff;
   assign out_side  = side2_ff;

endmodule

`default_nettype wire

FILE: rtl/gpa_out.sv
// Angle rounding, result register and skid stage toward the result channel.
`default_nettype none

module gpa_out (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  logic signed [gpa_pkg::ANGLE_W-1:0] in_pitch,
   input  gpa_pkg::side_type                  in_side,
   output logic                               pipe_en,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output gpa_pkg::rsp_type                   rsp_word
);
   import gpa_pkg::*;

   rsp_type res;
   rsp_type rsp_in;
   rsp_type rsp_ff;
   rsp_type skid_ff;
   logic    rsp_valid_in;
   logic    rsp_valid_ff;
   logic    skid_valid_in;
   logic    skid_valid_ff;
   logic    take;

   // Round both angles; no target forces zero angles
   always_comb begin
      res.no_target   = in_side.no_target;
      res.pitch_angle = in_side.no_target ? '0 : to_q13(in_pitch);
      res.yaw_angle   = in_side.no_target ? '0 : to_q13(in_side.aux_z);
   end

   // Hold the pipeline only while the skid word waits
   assign pipe_en = !skid_valid_ff;
   assign take    = !rsp_valid_ff || !rsp_stall;

   // Drain skid first, else load from the pipeline or park in skid
   always_comb begin
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (take) begin
         if (skid_valid_ff) begin
            rsp_in        = skid_ff;
            rsp_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            rsp_in       = res;
            rsp_valid_in = in_valid;
         end
      end else if (in_valid && pipe_en) begin
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (!take && pipe_en) begin
         skid_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // A parked word always sits behind a shown one
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid word held without a result shown");

   // A taken result with a parked word moves the parked word up
   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_stall && skid_valid_ff |=> rsp_valid_ff && !skid_valid_ff)
      else $error("skid word not moved to the result register");

   // No target means zero angles
   a_no_target_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.no_target |->
         rsp_ff.pitch_angle == '0 && rsp_ff.yaw_angle == '0)
      else $error("angles not zero without a target");

   // Angles stay within +-pi
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         $signed(rsp_ff.pitch_angle) <= 16'sd25736 &&
         $signed(rsp_ff.pitch_angle) >= -16'sd25736 &&
         $signed(rsp_ff.yaw_angle) <= 16'sd25736 &&
         $signed(rsp_ff.yaw_angle) >= -16'sd25736)
      else $error("angle beyond saturation limit");

endmodule

`default_nettype wire

FILE: rtl/gimbal_pointing_angles.sv
// Top level: target registers, difference stage and the two cascaded CORDIC passes.
//
// Usage:
//   Write the target position with csr_wr_en/csr_index/csr_wdata (x, y, z, then
//   target_valid) while no word is in flight. Each req word carries a current
//   position; each gives one rsp word with pitch and yaw in Q2.13 radians, or
//   no_target set and zero angles while target_valid is clear.
//   A word moves on either channel at a clock edge with valid high and stall low.
//   From acceptance to rsp_valid a word passes one difference stage, a
//   pre-rotation stage plus one stage per micro-rotation in each pass, two
//   gain-multiply stages and the result register.
//   Throughput is one word per cycle while req_stall is low; each micro-rotation
//   stage holds one 54-bit add, each gain stage partial products or their sum.
//   While rsp_stall holds a shown word, the pipeline keeps advancing until the
//   next word parks in a skid register; req_stall then stays high until the
//   shown word is taken and the skid word moves up into the result register.
//   Synchronous reset clears all valid bits and the target registers,
//   so no_target is reported until software sets target_valid.
`default_nettype none

module gimbal_pointing_angles (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  gpa_pkg::req_type                      req_word,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output gpa_pkg::rsp_type                      rsp_word,
   input  logic                                  csr_wr_en,
   input  logic [gpa_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [gpa_pkg::FIELD_W-1:0]           csr_wdata
);
   import gpa_pkg::*;

   logic [FIELD_W-1:0]          target_x_ff;
   logic [FIELD_W-1:0]          target_y_ff;
   logic [FIELD_W-1:0]          target_z_ff;
   logic                        target_valid_ff;

   logic                        en;
   logic signed [COORD_WIDTH:0] d_x;
   logic signed [COORD_WIDTH:0] d_y;
   logic signed [COORD_WIDTH:0] d_z;
   logic signed [DATA_W-1:0]    dx_in;
   logic signed [DATA_W-1:0]    dy_in;
   side_type                    side_in;
   logic                        e_valid_ff;
   logic signed [DATA_W-1:0]    dx_ff;
   logic signed [DATA_W-1:0]    dy_ff;
   side_type                    side_ff;

   logic                        p1_valid;
   logic signed [DATA_W-1:0]    p1_mag;
   logic signed [ANGLE_W-1:0]   p1_yaw;
   side_type                    p1_side;
   side_type                    g_side_in;

   logic                        g_valid;
   logic signed [DATA_W-1:0]    g_len;
   side_type                    g_side;

   logic                        p2_valid;
   logic signed [DATA_W-1:0]    p2_mag;
   logic signed [ANGLE_W-1:0]   p2_pitch;
   side_type                    p2_side;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         target_x_ff     <= '0;
         target_y_ff     <= '0;
         target_z_ff     <= '0;
         target_valid_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TARGET_X:     target_x_ff     <= csr_wdata;
            CSR_TARGET_Y:     target_y_ff     <= csr_wdata;
            CSR_TARGET_Z:     target_z_ff     <= csr_wdata;
            CSR_TARGET_VALID: target_valid_ff <= csr_wdata[0];
            default:          ;
         endcase
      end
   end

   assign req_stall = !en;

   // Form exact differences and scale them up to the 2^50 range
   always_comb begin
      d_x   = coord_ext(target_x_ff) - coord_ext(req_word.center_x);
      d_y   = coord_ext(target_y_ff) - coord_ext(req_word.center_y);
      d_z   = coord_ext(target_z_ff) - coord_ext(req_word.center_z);
      dx_in = DATA_W'(d_x) <<< GUARD_SHIFT;
      dy_in = DATA_W'(d_y) <<< GUARD_SHIFT;
      side_in.no_target = !target_valid_ff;
      side_in.aux_y     = -(DATA_W'(d_z) <<< GUARD_SHIFT);
      side_in.aux_z     = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (en) begin
         e_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         side_ff <= side_in;
      end
   end

   // First pass: yaw and the scaled horizontal length
   gpa_cordic_pass u_pass_yaw (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (e_valid_ff),
      .in_x      (dx_ff),
      .in_y      (dy_ff),
      .in_side   (side_ff),
      .out_valid (p1_valid),
      .out_mag   (p1_mag),
      .out_angle (p1_yaw),
      .out_side  (p1_side)
   );

   // Carry yaw along while the length is gain-corrected
   always_comb begin
      g_side_in       = p1_side;
      g_side_in.aux_z = p1_yaw;
   end

   gpa_gain u_gain (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p1_valid),
      .in_mag    (p1_mag),
      .in_side   (g_side_in),
      .out_valid (g_valid),
      .out_len   (g_len),
      .out_side  (g_side)
   );

   // Second pass: pitch from the length and -dz
   gpa_cordic_pass u_pass_pitch (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (g_valid),
      .in_x      (g_len),
      .in_y      (g_side.aux_y),
      .in_side   (g_side),
      .out_valid (p2_valid),
      .out_mag   (p2_mag),
      .out_angle (p2_pitch),
      .out_side  (p2_side)
   );

   gpa_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p2_valid && (p2_mag == p2_mag)),
      .in_pitch  (p2_pitch),
      .in_side   (p2_side),
      .pipe_en   (en),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire
